FILE: rtl/core/qat_pkg.sv
`default_nettype none

package qat_pkg;

    // most results one line character can cause
    localparam int MAX_RES = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_BS     = 8'h08;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_ARG_END  = 2'd1,
        KIND_LINE_END = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_quote;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_result;

    // all results of one request, in order; cnt is 1 to MAX_RES
    typedef struct packed {
        logic [1:0]                 cnt;
        t_result [MAX_RES-1:0]      res;
    } t_bundle;

    function automatic t_result mk_res(input t_kind kind, input logic [7:0] data);
        t_result r;
        r.kind = kind;
        r.data = (kind == KIND_DATA) ? data : 8'h00;
        return r;
    endfunction

    // byte for a backslash followed by a character that is not an octal digit
    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            CH_LC_R: v = CH_CR;
            CH_LC_N: v = CH_LF;
            CH_LC_F: v = CH_FF;
            CH_LC_T: v = CH_TAB;
            CH_LC_B: v = CH_BS;
            default: v = c;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qat_front.sv
`default_nettype none

module qat_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_ch,
    input  wire logic            i_line_end,
    input  wire logic            i_full,
    output logic                 o_push,
    output qat_pkg::t_bundle     o_bundle
);
    import qat_pkg::*;

    t_quote     r_quote, n_quote;
    logic       r_in_arg, n_in_arg;
    logic       r_bs, n_bs;
    logic [1:0] r_seen, n_seen;
    logic [7:0] r_oval, n_oval;

    t_bundle    bnd;
    logic [1:0] cnt;
    logic       done;
    logic       sep;
    logic       is_oct;
    logic       accept;

    assign accept = i_valid && !i_full;
    assign sep    = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
    assign is_oct = (i_ch >= CH_ZERO) && (i_ch <= CH_SEVEN);

    always_comb begin
        n_quote  = r_quote;
        n_in_arg = r_in_arg;
        n_bs     = r_bs;
        n_seen   = r_seen;
        n_oval   = r_oval;
        bnd      = '0;
        cnt      = 2'd0;
        done     = 1'b0;
        if (i_line_end) begin
            if (r_seen != 2'd0) begin
                bnd.res[cnt] = mk_res(KIND_DATA, r_oval);
                cnt = cnt + 2'd1;
            end
            if (r_in_arg) begin
                bnd.res[cnt] = mk_res(KIND_ARG_END, 8'h00);
                cnt = cnt + 2'd1;
            end
            bnd.res[cnt] = mk_res(KIND_LINE_END, 8'h00);
            cnt = cnt + 2'd1;
            n_quote  = Q_NONE;
            n_in_arg = 1'b0;
            n_bs     = 1'b0;
            n_seen   = 2'd0;
            n_oval   = 8'h00;
        end else begin
            // pending octal escape
            if (r_seen != 2'd0) begin
                if (is_oct) begin
                    n_oval = {r_oval[4:0], i_ch[2:0]};
                    n_seen = r_seen + 2'd1;
                    if (r_seen == 2'd2) begin
                        bnd.res[cnt] = mk_res(KIND_DATA, n_oval);
                        cnt = cnt + 2'd1;
                        n_seen = 2'd0;
                        n_oval = 8'h00;
                    end
                    done = 1'b1;
                end else begin
                    bnd.res[cnt] = mk_res(KIND_DATA, r_oval);
                    cnt = cnt + 2'd1;
                    n_seen = 2'd0;
                    n_oval = 8'h00;
                end
            end
            if (!done) begin
                if (r_bs) begin
                    n_bs = 1'b0;
                    if (is_oct) begin
                        n_oval = {5'b0, i_ch[2:0]};
                        n_seen = 2'd1;
                    end else begin
                        bnd.res[cnt] = mk_res(KIND_DATA, escape_map(i_ch));
                        cnt = cnt + 2'd1;
                    end
                end else if (r_in_arg || !sep) begin
                    n_in_arg = 1'b1;
                    if ((r_quote == Q_SINGLE && i_ch == CH_SQUOTE) ||
                        (r_quote == Q_DOUBLE && i_ch == CH_DQUOTE)) begin
                        n_quote = Q_NONE;
                    end else if (r_quote == Q_NONE && i_ch == CH_SQUOTE) begin
                        n_quote = Q_SINGLE;
                    end else if (r_quote == Q_NONE && i_ch == CH_DQUOTE) begin
                        n_quote = Q_DOUBLE;
                    end else if (i_ch == CH_BSLASH) begin
                        n_bs = 1'b1;
                    end else if (r_quote != Q_NONE || !sep) begin
                        bnd.res[cnt] = mk_res(KIND_DATA, i_ch);
                        cnt = cnt + 2'd1;
                    end else begin
                        bnd.res[cnt] = mk_res(KIND_ARG_END, 8'h00);
                        cnt = cnt + 2'd1;
                        n_in_arg = 1'b0;
                    end
                end
            end
        end
        bnd.cnt = cnt;
    end

    assign o_bundle = bnd;
    assign o_push   = accept && (cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote  <= Q_NONE;
            r_in_arg <= 1'b0;
            r_bs     <= 1'b0;
            r_seen   <= 2'd0;
            r_oval   <= 8'h00;
        end else if (accept) begin
            r_quote  <= n_quote;
            r_in_arg <= n_in_arg;
            r_bs     <= n_bs;
            r_seen   <= n_seen;
            r_oval   <= n_oval;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/qat_queue.sv
`default_nettype none

module qat_queue #(
    parameter int P_DEPTH = qat_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire qat_pkg::t_bundle i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output qat_pkg::t_bundle      o_data
);
    import qat_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_bundle         r_mem [P_DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(P_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= bump(r_wr);
            end
            if (do_pop) begin
                r_rd <= bump(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/qat_back.sv
`default_nettype none

module qat_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire qat_pkg::t_bundle i_q_data,
    output logic                  o_q_pop,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output qat_pkg::t_result      o_res,
    output logic                  o_last
);
    import qat_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_result    r_res;
    logic       r_last;
    logic       load;
    logic       last;

    assign load    = i_q_valid && (!r_valid || !i_stall);
    assign last    = (r_idx == i_q_data.cnt - 2'd1);
    assign o_q_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= i_q_data.res[r_idx];
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

endmodule

`default_nettype wire

FILE: rtl/core/quoted_argument_tokenizer_core.sv
// quoted argument tokenizer: splits a line, one character per request, into arguments
// input channel: i_valid / o_stall carry i_ch and i_line_end; a request is taken at a
//   clock edge with i_valid high and o_stall low; i_line_end high closes the line
// output channel: o_valid / i_stall carry o_item_kind (data, end of argument, end of
//   line), o_out_byte and o_last_of_run, set on the final result of each request
// a taken request's results pass through the queue and then the output register before o_valid
// throughput: one request per cycle while each gives at most one result and i_stall is
//   low; a request with k results sends them through the output register one by one, the
//   shared result register being the limit; the queue between the parts absorbs the bursts
// o_stall is high only while the queue of pending result groups is full
// requests that give no result (separators outside an argument, quotes, backslashes) never
//   reach the queue
// reset (synchronous, active low) clears the quote, argument and escape state, empties
//   the queue and drops o_valid
// while i_stall is high the shown result holds and the front keeps taking requests
//   until the queue fills
`default_nettype none

module quoted_argument_tokenizer_core #(
    parameter int P_QUEUE_DEPTH = qat_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_line_end,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_item_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);
    import qat_pkg::*;

    // front to queue
    logic    q_push;
    t_bundle q_in;
    logic    q_full;
    // queue to back
    logic    q_valid;
    t_bundle q_out;
    logic    q_pop;
    t_result res;

    // the front classifies each character and updates the tokenizer state
    qat_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_ch       (i_ch),
        .i_line_end (i_line_end),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_bundle   (q_in)
    );

    // result groups wait here while the receiver stalls
    qat_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // the back sends one result per cycle into the output register unless i_stall holds it
    qat_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_res     (res),
        .o_last    (o_last_of_run)
    );

    assign o_stall     = q_full;
    assign o_item_kind = res.kind;
    assign o_out_byte  = res.data;

`ifndef ASSERT_OFF
    // byte lane is zero on every mark
    a_mark_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_kind != KIND_DATA) |-> (o_out_byte == 8'h00))
        else $error("mark carries a nonzero byte");

    // end of line is always the last result of its request
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_kind == KIND_LINE_END) |-> o_last_of_run)
        else $error("line end not last of run");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    // a pushed group always holds at least one result
    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_in.cnt != 2'd0))
        else $error("empty result group pushed");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qat_pkg::*;

    // run ends with a failure if it takes longer than this
    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_ITEMS  = 70;
    localparam int LONG_HOLD_LEN = 150;
    localparam int LONG_HOLD_AT  = 35;
    localparam int TAIL_CYCLES   = 20;

    // one line character as the sender offers it
    typedef struct {
        logic [7:0] ch;
        logic       line_end;
        logic       drain_first;  // hold off until every expected token has come
    } t_line_char;

    // one token the block is expected to produce
    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_arg_token;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic [7:0] i_ch       = 8'h00;
    logic       i_line_end = 1'b0;
    logic       i_stall    = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_item_kind;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    quoted_argument_tokenizer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_line_end    (i_line_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_item_kind   (o_item_kind),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    t_line_char line_chars[$];
    t_arg_token expected_tokens[$];

    int err_cnt   = 0;
    int n_taken   = 0;
    int n_queued  = 0;
    int cycle_cnt = 0;
    int drain_at1 = 0;
    int drain_at2 = 0;

    // tokenizer state kept by the predictor
    t_quote     tk_quote;
    logic       tk_in_arg;
    logic       tk_after_bs;
    logic [1:0] tk_oct_n;
    logic [7:0] tk_oct_v;

    // tokens produced by the request being predicted
    t_arg_token step_tokens[MAX_RES];
    int         step_n;

    // sender burst control
    int burst_left = 0;
    int gap_left   = 0;

    // receiver pattern control
    t_rx_mode rx_mode        = RX_FREE;
    int       rx_mode_cycles = 0;
    int       hold_left      = 0;
    logic     long_hold_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic tok_reset();
        tk_quote    = Q_NONE;
        tk_in_arg   = 1'b0;
        tk_after_bs = 1'b0;
        tk_oct_n    = 2'd0;
        tk_oct_v    = 8'h00;
    endtask

    task automatic tok_emit(input t_kind kind, input logic [7:0] data);
        t_arg_token t;
        t.kind = kind;
        t.data = (kind == KIND_DATA) ? data : 8'h00;
        t.last = 1'b0;
        step_tokens[step_n] = t;
        step_n++;
    endtask

    task automatic tok_flush_octal();
        if (tk_oct_n != 2'd0) begin
            tok_emit(KIND_DATA, tk_oct_v);
            tk_oct_n = 2'd0;
            tk_oct_v = 8'h00;
        end
    endtask

    function automatic logic is_octal_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // character after a backslash
    task automatic tok_escape(input logic [7:0] c);
        logic [7:0] v;
        if (is_octal_digit(c)) begin
            tk_oct_v = {5'd0, c[2:0]};
            tk_oct_n = 2'd1;
        end else begin
            if (c == CH_LC_R)      v = CH_CR;
            else if (c == CH_LC_N) v = CH_LF;
            else if (c == CH_LC_F) v = CH_FF;
            else if (c == CH_LC_T) v = CH_TAB;
            else if (c == CH_LC_B) v = CH_BS;
            else                   v = c;
            tok_emit(KIND_DATA, v);
        end
    endtask

    // works out the tokens of one accepted request and queues them
    task automatic tokenize_char(input logic [7:0] c, input logic le);
        logic       sep;
        logic       done;
        logic [7:0] close_q;
        t_arg_token t;
        step_n  = 0;
        sep     = (c == CH_SPACE) || (c == CH_TAB);
        done    = 1'b0;
        close_q = (tk_quote == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        if (le) begin
            // pending octal byte, open argument, then the line end itself
            tok_flush_octal();
            if (tk_in_arg)
                tok_emit(KIND_ARG_END, 8'h00);
            tok_emit(KIND_LINE_END, 8'h00);
            tok_reset();
        end else begin
            if (tk_oct_n != 2'd0) begin
                if (is_octal_digit(c)) begin
                    // built modulo 256, third digit emits at once
                    tk_oct_v = {tk_oct_v[4:0], 3'b000} + {5'd0, c[2:0]};
                    tk_oct_n = tk_oct_n + 2'd1;
                    if (tk_oct_n == 2'd3)
                        tok_flush_octal();
                    done = 1'b1;
                end else begin
                    tok_flush_octal();
                end
            end
            if (!done && tk_after_bs) begin
                tk_after_bs = 1'b0;
                tok_escape(c);
                done = 1'b1;
            end
            if (!done && !tk_in_arg) begin
                if (sep)
                    done = 1'b1;
                else
                    tk_in_arg = 1'b1;
            end
            if (!done && tk_quote != Q_NONE && c == close_q) begin
                tk_quote = Q_NONE;
                done     = 1'b1;
            end
            if (!done && tk_quote == Q_NONE && (c == CH_SQUOTE || c == CH_DQUOTE)) begin
                tk_quote = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
                done     = 1'b1;
            end
            if (!done && c == CH_BSLASH) begin
                tk_after_bs = 1'b1;
                done        = 1'b1;
            end
            if (!done) begin
                if (tk_quote != Q_NONE || !sep) begin
                    tok_emit(KIND_DATA, c);
                end else begin
                    tok_emit(KIND_ARG_END, 8'h00);
                    tk_in_arg = 1'b0;
                end
            end
        end
        for (int i = 0; i < step_n; i++) begin
            t      = step_tokens[i];
            t.last = (i == step_n - 1);
            expected_tokens.push_back(t);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    task automatic add_char(input logic [7:0] c);
        t_line_char it;
        it.ch          = c;
        it.line_end    = 1'b0;
        it.drain_first = (n_queued == drain_at1) || (n_queued == drain_at2);
        line_chars.push_back(it);
        n_queued++;
    endtask

    task automatic add_eol();
        t_line_char it;
        // ch is ignored on a line end, so it carries random bits
        it.ch          = 8'($urandom_range(1, 255));
        it.line_end    = 1'b1;
        it.drain_first = (n_queued == drain_at1) || (n_queued == drain_at2);
        line_chars.push_back(it);
        n_queued++;
    endtask

    task automatic add_random_escape();
        int unsigned sel;
        int unsigned ndig;
        add_char(CH_BSLASH);
        sel = $urandom_range(0, 9);
        case (sel)
            0: add_char(CH_LC_R);
            1: add_char(CH_LC_N);
            2: add_char(CH_LC_F);
            3: add_char(CH_LC_T);
            4: add_char(CH_LC_B);
            5, 6, 7: begin
                // one to four digits: a fourth one lands as a plain character
                ndig = $urandom_range(1, 4);
                for (int k = 0; k < ndig; k++)
                    add_char(CH_ZERO + 8'($urandom_range(0, 7)));
            end
            8: add_char(8'($urandom_range(1, 255)));
            default: begin
                if ($urandom_range(0, 1) == 0)
                    add_char(CH_BSLASH);
                else
                    add_char($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
            end
        endcase
    endtask

    task automatic build_stimulus();
        int unsigned len;
        int unsigned sel;
        int          rand_start;

        // min and max bytes, tab separator, escape inside double quotes
        add_char(8'h01);
        add_char(CH_TAB);
        add_char(CH_DQUOTE);
        add_char(8'hff);
        add_char(CH_BSLASH);
        add_char(CH_LC_N);
        add_char(CH_DQUOTE);
        add_eol();
        // octal overflow, octal cut short by a letter, open quote with backslash at eol
        add_char(CH_BSLASH);
        add_char(CH_SEVEN);
        add_char(CH_SEVEN);
        add_char(CH_SEVEN);
        add_char(CH_BSLASH);
        add_char(CH_ZERO + 8'd1);
        add_char(CH_LC_R);
        add_char(CH_SPACE);
        add_char(CH_SQUOTE);
        add_char(CH_BSLASH);
        add_eol();
        // octal byte still pending at the line end
        add_char(CH_BSLASH);
        add_char(CH_ZERO);
        add_char(CH_ZERO + 8'd5);
        add_eol();

        rand_start = n_queued;
        drain_at1  = rand_start + 5;
        drain_at2  = rand_start + 60;
        while (n_queued - rand_start < RANDOM_ITEMS) begin
            len = $urandom_range(0, 12);
            for (int k = 0; k < len; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 30)
                    add_char(8'($urandom_range(1, 255)));
                else if (sel < 48)
                    add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                else if (sel < 60)
                    add_char($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
                else if (sel < 80)
                    add_random_escape();
                else if (sel < 84)
                    add_char(CH_BSLASH);  // lone backslash, may hit the line end
                else
                    add_char(8'h61 + 8'($urandom_range(0, 25)));
            end
            add_eol();
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_ch       <= 8'h00;
            i_line_end <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                tokenize_char(i_ch, i_line_end);
                n_taken++;
            end
            if (i_valid && o_stall) begin
                // stalled request holds its payload
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (line_chars.size() > 0 &&
                         !(line_chars[0].drain_first && expected_tokens.size() != 0)) begin
                i_valid    <= 1'b1;
                i_ch       <= line_chars[0].ch;
                i_line_end <= line_chars[0].line_end;
                line_chars.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // next burst; some run without any gap
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_arg_token e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token: item_kind %0d out_byte %02h last_of_run %0b",
                           o_item_kind, o_out_byte, o_last_of_run);
                    err_cnt++;
                end else begin
                    e = expected_tokens.pop_front();
                    if (o_item_kind !== e.kind) begin
                        $error("item_kind: expected %0d, actual %0d", e.kind, o_item_kind);
                        err_cnt++;
                    end
                    if (o_out_byte !== e.data) begin
                        $error("out_byte: expected %02h, actual %02h", e.data, o_out_byte);
                        err_cnt++;
                    end
                    if (o_last_of_run !== e.last) begin
                        $error("last_of_run: expected %0b, actual %0b", e.last, o_last_of_run);
                        err_cnt++;
                    end
                end
            end

            rx_mode_cycles++;
            if (rx_mode_cycles >= 50) begin
                rx_mode_cycles = 0;
                rx_mode        = t_rx_mode'($urandom_range(0, 3));
            end

            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!long_hold_done && n_taken >= LONG_HOLD_AT) begin
                // long hold-off: the block fills up and stalls its input
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_LEN;
                i_stall        <= 1'b1;
            end else begin
                case (rx_mode)
                    RX_FREE:     i_stall <= 1'b0;
                    RX_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    i_stall <= ($urandom_range(0, 9) < 7);
                    RX_PERIODIC: i_stall <= (rx_mode_cycles % 3 != 0);
                    default:     i_stall <= 1'b0;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        tok_reset();
        build_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (line_chars.size() == 0 && !i_valid);
        wait (expected_tokens.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/qat_pkg.sv
rtl/core/qat_front.sv
rtl/core/qat_queue.sv
rtl/core/qat_back.sv
rtl/core/quoted_argument_tokenizer_core.sv
test/tb_top.sv
